@@ rtl/core/hpm_pkg.sv @@
package hpm_pkg;

  localparam int MaxBlock     = 8;
  localparam int PatternCount = 16;
  localparam int SlotW        = 4;
  localparam int PickW        = 4;
  localparam int CountW       = 7;
  localparam int SumW         = 16;
  localparam int DivW         = 20;
  localparam int DivisorW     = 16;
  localparam int FullPixel    = 255 * 3;
  localparam logic [7:0] LevelOn  = 8'd255;
  localparam logic [7:0] LevelOff = 8'd0;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_LOAD  = 1'b1
  } op_e;

  typedef enum logic [3:0] {
    REG_BLOCK_SIZE    = 4'd0,
    REG_PATTERN_SCALE = 4'd1
  } reg_idx_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_READ,
    BK_EMIT
  } back_state_e;

  typedef struct packed {
    logic               is_load;
    logic [SlotW-1:0]   slot;
    logic [63:0]        bits;
    logic [SumW-1:0]    sum;
    logic [CountW-1:0]  count;
    logic [3:0]         scale;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [CountW-1:0] tile_count(logic [3:0] block_size);
    logic [3:0] e;
    e = block_size;
    if (e == 4'd0) e = 4'd1;
    if (e > 4'(MaxBlock)) e = 4'(MaxBlock);
    return CountW'(e) * CountW'(e);
  endfunction

endpackage

@@ rtl/core/hpm_if.sv @@
interface hpm_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [3:0]  pattern_slot;
  logic [63:0] pattern_bits;

  modport source (output valid, operation, red, green, blue, pattern_slot, pattern_bits,
                  input ready);
  modport sink (input valid, operation, red, green, blue, pattern_slot, pattern_bits,
                output ready);
endinterface

interface hpm_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_level;
  logic [3:0] pattern_used;
  logic       tile_last;

  modport source (output valid, pixel_level, pattern_used, tile_last, input ready);
  modport sink (input valid, pixel_level, pattern_used, tile_last, output ready);
endinterface

interface hpm_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] index;
  logic [3:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/core/hpm_front.sv @@
module hpm_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  hpm_in_if.sink           in_i,
  hpm_cfg_if.sink          cfg_i,
  input  hpm_pkg::q_status_t q_status_i,
  output logic             push_o,
  output hpm_pkg::job_t    job_o
);
  import hpm_pkg::*;

  logic [3:0]        block_size_q;
  logic [3:0]        scale_q;
  logic [SumW-1:0]   sum_q, sum_d;
  logic [CountW-1:0] seen_q, seen_d;
  logic [CountW-1:0] count;
  logic              accept;
  logic              tile_end;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = !q_status_i.full;
  assign accept      = in_i.valid && in_i.ready;
  assign count       = tile_count(block_size_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_size_q <= 4'd4;
      scale_q      <= 4'd15;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_BLOCK_SIZE:    block_size_q <= cfg_i.data;
        REG_PATTERN_SCALE: scale_q      <= cfg_i.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    sum_d    = sum_q + SumW'(in_i.red) + SumW'(in_i.green) + SumW'(in_i.blue);
    seen_d   = seen_q + CountW'(1);
    tile_end = seen_d >= count;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      seen_q <= '0;
    end else if (accept && in_i.operation == OP_PIXEL) begin
      if (tile_end) begin
        sum_q  <= '0;
        seen_q <= '0;
      end else begin
        sum_q  <= sum_d;
        seen_q <= seen_d;
      end
    end
  end

  always_comb begin
    push_o        = accept && (in_i.operation == OP_LOAD || tile_end);
    job_o.is_load = in_i.operation == OP_LOAD;
    job_o.slot    = in_i.pattern_slot;
    job_o.bits    = in_i.pattern_bits;
    job_o.sum     = sum_d;
    job_o.count   = count;
    job_o.scale   = scale_q;
  end

endmodule

@@ rtl/core/hpm_queue.sv @@
module hpm_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  hpm_pkg::job_t      job_i,
  input  logic               pop_i,
  output hpm_pkg::job_t      job_o,
  output hpm_pkg::q_status_t status_o
);
  import hpm_pkg::*;

  job_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] fill_q;
  logic       do_push, do_pop;

  assign status_o.full  = fill_q == 2'd2;
  assign status_o.empty = fill_q == 2'd0;
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign job_o          = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop)  rd_ptr_q <= !rd_ptr_q;
      case ({do_push, do_pop})
        2'b10:   fill_q <= fill_q + 2'd1;
        2'b01:   fill_q <= fill_q - 2'd1;
        default: fill_q <= fill_q;
      endcase
    end
  end

endmodule

@@ rtl/core/hpm_back.sv @@
module hpm_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hpm_pkg::job_t      job_i,
  input  hpm_pkg::q_status_t q_status_i,
  output logic               pop_o,
  hpm_out_if.source          out_o
);
  import hpm_pkg::*;

  logic [63:0]         table_q [PatternCount];
  logic [63:0]         pattern_q;
  back_state_e         state_q, state_d;
  logic [DivW-1:0]     rem_q, rem_d;
  logic [DivisorW-1:0] divisor_q;
  logic [2:0]          step_q, step_d;
  logic [PickW-1:0]    pick_q, pick_d;
  logic [CountW-1:0]   count_q;
  logic [5:0]          k_q, k_d;
  logic [DivW-1:0]     shifted;
  logic                last;
  logic                start;

  assign shifted = DivW'(divisor_q) << step_q;
  assign last    = (CountW'(k_q) + CountW'(1)) == count_q;
  assign start   = pop_o && !job_i.is_load;

  always_comb begin
    state_d = state_q;
    rem_d   = rem_q;
    step_d  = step_q;
    pick_d  = pick_q;
    k_d     = k_q;
    pop_o   = 1'b0;
    case (state_q)
      BK_IDLE: begin
        pop_o = !q_status_i.empty;
        if (!q_status_i.empty && !job_i.is_load) begin
          state_d = BK_DIV;
          rem_d   = DivW'(job_i.scale) * DivW'(job_i.sum);
          step_d  = 3'd4;
          pick_d  = '0;
        end
      end
      BK_DIV: begin
        if (step_q == 3'd4) begin
          if (rem_q >= shifted) begin
            pick_d  = PickW'(PatternCount - 1);
            state_d = BK_READ;
          end else begin
            step_d = 3'd3;
          end
        end else begin
          if (rem_q >= shifted) begin
            rem_d = rem_q - shifted;
            pick_d[step_q[1:0]] = 1'b1;
          end
          if (step_q == 3'd0) begin
            state_d = BK_READ;
          end else begin
            step_d = step_q - 3'd1;
          end
        end
      end
      BK_READ: begin
        state_d = BK_EMIT;
        k_d     = '0;
      end
      BK_EMIT: begin
        if (out_o.ready) begin
          k_d = k_q + 6'd1;
          if (last) state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    step_q <= step_d;
    pick_q <= pick_d;
    k_q    <= k_d;
    if (start) begin
      divisor_q <= DivisorW'(FullPixel * int'(job_i.count));
      count_q   <= job_i.count;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && job_i.is_load && int'(job_i.slot) < PatternCount) begin
      table_q[job_i.slot] <= job_i.bits;
    end
    if (state_q == BK_READ) begin
      pattern_q <= table_q[pick_q];
    end
  end

  assign out_o.valid        = state_q == BK_EMIT;
  assign out_o.pixel_level  = pattern_q[k_q] ? LevelOn : LevelOff;
  assign out_o.pattern_used = pick_q;
  assign out_o.tile_last    = last;

endmodule

@@ rtl/core/block_halftone_pattern_mask.sv @@
// Channel  Direction  Word
// in_i     sink       operation, red, green, blue, pattern_slot, pattern_bits
// out_o    source     pixel_level, pattern_used, tile_last
// cfg_i    sink       index, data (block_size = 0, pattern_scale = 1)
//
// Input words are taken one per cycle while the two-entry job queue has room.
// Each completed tile passes through the back end as product, index division
// (one quotient bit per cycle, cut short when the index saturates), table
// read and output words. A load is written to the table as it is popped.
// Reset clears the tile sums, the queue and the back-end state; the pattern
// table holds nothing valid until loaded. Either side may stall at any time.
module block_halftone_pattern_mask (
  input  logic     clk_i,
  input  logic     rst_ni,
  hpm_in_if.sink   in_i,
  hpm_cfg_if.sink  cfg_i,
  hpm_out_if.source out_o
);
  import hpm_pkg::*;

  job_t      push_job, head_job;
  logic      push, pop;
  q_status_t q_status;

  hpm_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .cfg_i      (cfg_i),
    .q_status_i (q_status),
    .push_o     (push),
    .job_o      (push_job)
  );

  hpm_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .job_i    (push_job),
    .pop_i    (pop),
    .job_o    (head_job),
    .status_o (q_status)
  );

  hpm_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_i      (head_job),
    .q_status_i (q_status),
    .pop_o      (pop),
    .out_o      (out_o)
  );

endmodule

@@ test/block_halftone_pattern_mask_tb.sv @@
module block_halftone_pattern_mask_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hpm_pkg::*;

  localparam int SettleCycles = 20;
  localparam int LongHold     = 300;
  localparam int QuietLimit   = 3000;

  typedef struct packed {
    op_e              operation;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [SlotW-1:0] pattern_slot;
    logic [63:0]      pattern_bits;
  } tile_input_t;

  typedef struct packed {
    logic [7:0]       pixel_level;
    logic [PickW-1:0] pattern_used;
    logic             tile_last;
  } mask_pixel_t;

  class tile_mask_scoreboard;
    logic [3:0]        size_reg  = 4'd4;
    logic [3:0]        scale_reg = 4'd15;
    logic [SumW-1:0]   sum_acc   = '0;
    logic [CountW-1:0] seen      = '0;
    logic [63:0]       patterns [PatternCount];
    mask_pixel_t       pixels_due [$];
    int                errors    = 0;

    function void set_register(logic [3:0] index, logic [3:0] data);
      if (index == REG_BLOCK_SIZE) size_reg = data;
      else if (index == REG_PATTERN_SCALE) scale_reg = data;
    endfunction

    function int tile_area();
      int side;
      side = (size_reg == 4'd0) ? 1 : (size_reg > MaxBlock) ? MaxBlock : int'(size_reg);
      return side * side;
    endfunction

    function void take_word(tile_input_t w);
      int area;
      int pick;
      mask_pixel_t px;
      if (w.operation == OP_LOAD) begin
        if (w.pattern_slot < PatternCount) patterns[w.pattern_slot] = w.pattern_bits;
        return;
      end
      sum_acc = sum_acc + w.red + w.green + w.blue;
      seen = seen + 1'b1;
      area = tile_area();
      if (int'(seen) < area) return;
      pick = (int'(scale_reg) * int'(sum_acc)) / (FullPixel * area);
      if (pick > PatternCount - 1) pick = PatternCount - 1;
      for (int k = 0; k < area; k++) begin
        px.pixel_level  = patterns[pick][k] ? LevelOn : LevelOff;
        px.pattern_used = PickW'(pick);
        px.tile_last    = (k == area - 1);
        pixels_due.push_back(px);
      end
      sum_acc = '0;
      seen = '0;
    endfunction

    function void check_pixel(mask_pixel_t got);
      mask_pixel_t want;
      if (pixels_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none, actual level %0d pattern %0d last %0d",
                 $time, got.pixel_level, got.pattern_used, got.tile_last);
        return;
      end
      want = pixels_due.pop_front();
      if (got.pixel_level !== want.pixel_level) begin
        errors++;
        $display("%0t: pixel_level expected %0d actual %0d",
                 $time, want.pixel_level, got.pixel_level);
      end
      if (got.pattern_used !== want.pattern_used) begin
        errors++;
        $display("%0t: pattern_used expected %0d actual %0d",
                 $time, want.pattern_used, got.pattern_used);
      end
      if (got.tile_last !== want.tile_last) begin
        errors++;
        $display("%0t: tile_last expected %0d actual %0d",
                 $time, want.tile_last, got.tile_last);
      end
    endfunction

    function int pending();
      return pixels_due.size();
    endfunction
  endclass

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  bit   calm      = 1'b0;
  int   idle_odds = 5;
  logic hold_req  = 1'b0;
  int   hold_left = 0;
  int   gap_left  = 0;
  int   quiet     = 0;

  tile_mask_scoreboard sb = new;

  hpm_in_if  in_if ();
  hpm_cfg_if cfg_if ();
  hpm_out_if out_if ();

  block_halftone_pattern_mask DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .out_o  (out_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (hold_req) begin
        hold_req <= 1'b0;
        hold_left = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        out_if.ready <= 1'b0;
      end else if (!calm && $urandom_range(idle_odds, 0) == 0) begin
        gap_left = $urandom_range(18, 0);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : watch_channels
    tile_input_t word_in;
    mask_pixel_t word_out;
    if (rst_n) begin
      quiet++;
      if (out_if.valid && out_if.ready) begin
        word_out = '{out_if.pixel_level, out_if.pattern_used, out_if.tile_last};
        sb.check_pixel(word_out);
        quiet = 0;
      end
      if (in_if.valid && in_if.ready) begin
        word_in = '{op_e'(in_if.operation), in_if.red, in_if.green, in_if.blue,
                    in_if.pattern_slot, in_if.pattern_bits};
        sb.take_word(word_in);
        quiet = 0;
      end
      if (cfg_if.valid && cfg_if.ready) begin
        sb.set_register(cfg_if.index, cfg_if.data);
        quiet = 0;
      end
      if (quiet >= QuietLimit) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  function automatic tile_input_t pixel_word(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    tile_input_t w;
    w.operation    = OP_PIXEL;
    w.red          = r;
    w.green        = g;
    w.blue         = b;
    w.pattern_slot = SlotW'($urandom_range(PatternCount - 1, 0));
    w.pattern_bits = {$urandom, $urandom};
    return w;
  endfunction

  function automatic tile_input_t load_word(logic [SlotW-1:0] slot, logic [63:0] bits_in);
    tile_input_t w;
    w.operation    = OP_LOAD;
    w.red          = 8'($urandom);
    w.green        = 8'($urandom);
    w.blue         = 8'($urandom);
    w.pattern_slot = slot;
    w.pattern_bits = bits_in;
    return w;
  endfunction

  function automatic logic [7:0] shade(logic [7:0] tone);
    return ($urandom_range(3, 0) != 0) ? tone : 8'($urandom_range(255, 0));
  endfunction

  task automatic send_word(input tile_input_t w);
    if (!calm && $urandom_range(idle_odds, 0) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(19, 1)) @(posedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.operation    <= w.operation;
    in_if.red          <= w.red;
    in_if.green        <= w.green;
    in_if.blue         <= w.blue;
    in_if.pattern_slot <= w.pattern_slot;
    in_if.pattern_bits <= w.pattern_bits;
    do @(posedge clk); while (!in_if.ready);
  endtask

  task automatic write_reg(input logic [3:0] index, input logic [3:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= index;
    cfg_if.data  <= data;
    do @(posedge clk); while (!cfg_if.ready);
  endtask

  // Loads and partial tiles leave no pixels to wait for, so the back end
  // is left to settle before anything else happens.
  task automatic drain_tiles();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic run_tiles(input logic [3:0] size, input logic [3:0] scale, input int count,
                           input int odds, input bit squeeze);
    int tile_pos;
    logic [7:0] tone;
    tile_pos = 0;
    tone = 8'd0;
    if ($urandom_range(1, 0) == 1)
      write_reg(4'($urandom_range(15, REG_PATTERN_SCALE + 1)), 4'($urandom));
    write_reg(REG_BLOCK_SIZE, size);
    write_reg(REG_PATTERN_SCALE, scale);
    cfg_if.valid <= 1'b0;
    idle_odds = odds;
    if (squeeze) hold_req <= 1'b1;
    for (int i = 0; i < count; i++) begin
      if (i == count / 2 && !calm) drain_tiles();
      if ($urandom_range(99, 0) < 8) begin
        send_word(load_word(SlotW'($urandom_range(PatternCount - 1, 0)), {$urandom, $urandom}));
      end else begin
        if (tile_pos == 0) begin
          case ($urandom_range(3, 0))
            0: tone = 8'd0;
            1: tone = 8'd255;
            default: tone = 8'($urandom);
          endcase
        end
        send_word(pixel_word(shade(tone), shade(tone), shade(tone)));
        tile_pos = (tile_pos + 1) % sb.tile_area();
      end
    end
    drain_tiles();
  endtask

  initial begin
    in_if.valid        = 1'b0;
    in_if.operation    = OP_PIXEL;
    in_if.red          = '0;
    in_if.green        = '0;
    in_if.blue         = '0;
    in_if.pattern_slot = '0;
    in_if.pattern_bits = '0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = '0;
    cfg_if.data        = '0;
    out_if.ready       = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Every table entry is loaded first so that no tile reads an empty slot.
    for (int s = 0; s < PatternCount; s++) begin
      if (s == 0) send_word(load_word(SlotW'(s), 64'd0));
      else if (s == PatternCount - 1) send_word(load_word(SlotW'(s), {64{1'b1}}));
      else if (s == 1) send_word(load_word(SlotW'(s), {32{2'b10}}));
      else send_word(load_word(SlotW'(s), {$urandom, $urandom}));
    end
    drain_tiles();
    write_reg(REG_BLOCK_SIZE, 4'd1);
    write_reg(REG_PATTERN_SCALE, 4'd15);
    cfg_if.valid <= 1'b0;
    send_word(pixel_word(8'd255, 8'd255, 8'd255));
    send_word(pixel_word(8'd0, 8'd0, 8'd0));
    send_word(pixel_word(8'd200, 8'd17, 8'd90));
    drain_tiles();

    // Shrinking the tile partway through closes it on the next pixel, and
    // the oversized sum forces the index to saturate.
    write_reg(REG_BLOCK_SIZE, 4'd2);
    cfg_if.valid <= 1'b0;
    send_word(pixel_word(8'd255, 8'd0, 8'd255));
    send_word(pixel_word(8'd255, 8'd255, 8'd255));
    send_word(pixel_word(8'd0, 8'd255, 8'd255));
    drain_tiles();
    write_reg(REG_BLOCK_SIZE, 4'd1);
    cfg_if.valid <= 1'b0;
    send_word(pixel_word(8'd255, 8'd255, 8'd255));
    drain_tiles();

    run_tiles(4'd2, 4'd15, 40, 5, 1'b0);
    run_tiles(4'd0, 4'd7, 30, 5, 1'b1);
    run_tiles(4'd8, 4'd0, 70, 9, 1'b0);
    run_tiles(4'd15, 4'd12, 40, 5, 1'b0);
    calm = 1'b1;
    run_tiles(4'd3, 4'd9, 30, 5, 1'b0);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
